// ----- src/ppf_pkg.sv -----
package ppf_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SEP,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_HEADER   = 2'd1,
        KIND_BADMAGIC = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] color;
        logic [15:0] width;
        logic [15:0] height;
    } t_req;

    localparam logic [7:0] MAGIC0_BYTE  = 8'h50;
    localparam logic [7:0] MAGIC1_BYTE  = 8'h36;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;

    localparam logic [1:0] BIP_RED   = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_BLUE  = 2'd2;

    localparam logic REG_FRAME_BASE  = 1'b0;
    localparam logic REG_LINE_STRIDE = 1'b1;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

endpackage

// ----- src/ppf_front.sv -----
module ppf_front #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    output logic                o_req_valid,
    output ppf_pkg::t_req       o_req,
    output logic [DIM_BITS-1:0] o_row,
    output logic [DIM_BITS-1:0] o_col,
    input  logic                i_req_ready
);
    import ppf_pkg::*;

    localparam int ACC_BITS = DIM_BITS + 5;

    t_phase              r_phase, n_phase, cur_phase;
    logic [DIM_BITS-1:0] r_width, n_width, cur_width;
    logic [DIM_BITS-1:0] r_height, n_height, cur_height;
    logic [1:0]          r_bip, n_bip, cur_bip;
    logic [7:0]          r_red, n_red, cur_red;
    logic [7:0]          r_green, n_green, cur_green;
    logic [DIM_BITS-1:0] r_col, n_col, cur_col;
    logic [DIM_BITS-1:0] r_row, n_row, cur_row;
    logic [DIM_BITS-1:0] col_inc;
    logic [31:0]         width_ext;
    logic [31:0]         height_ext;
    logic                produce;
    logic                accept;

    function automatic logic [DIM_BITS-1:0] f_add_digit(
        input logic [DIM_BITS-1:0] acc,
        input logic [7:0]          b
    );
        logic [7:0]          digit;
        logic [ACC_BITS-1:0] wide;
        logic [ACC_BITS-1:0] sum;
        logic [ACC_BITS-1:0] limit;
        digit = b - DIGIT_ZERO;
        wide  = ACC_BITS'(acc);
        limit = ACC_BITS'({DIM_BITS{1'b1}});
        sum   = (wide << 3) + (wide << 1) + ACC_BITS'(digit);
        if (sum > limit) begin
            f_add_digit = {DIM_BITS{1'b1}};
        end else begin
            f_add_digit = sum[DIM_BITS-1:0];
        end
    endfunction

    assign o_ready = i_req_ready;
    assign accept  = i_valid && i_req_ready;

    always_comb begin
        if (i_start) begin
            cur_phase  = PH_MAGIC0;
            cur_width  = '0;
            cur_height = '0;
            cur_bip    = BIP_RED;
            cur_red    = '0;
            cur_green  = '0;
            cur_col    = '0;
            cur_row    = '0;
        end else begin
            cur_phase  = r_phase;
            cur_width  = r_width;
            cur_height = r_height;
            cur_bip    = r_bip;
            cur_red    = r_red;
            cur_green  = r_green;
            cur_col    = r_col;
            cur_row    = r_row;
        end
    end

    assign col_inc = cur_col + 1'b1;

    always_comb begin
        n_phase  = cur_phase;
        n_width  = cur_width;
        n_height = cur_height;
        n_bip    = cur_bip;
        n_red    = cur_red;
        n_green  = cur_green;
        n_col    = cur_col;
        n_row    = cur_row;
        unique case (cur_phase)
            PH_MAGIC0: begin
                n_phase = (i_byte == MAGIC0_BYTE) ? PH_MAGIC1 : PH_HALT;
            end
            PH_MAGIC1: begin
                n_phase = (i_byte == MAGIC1_BYTE) ? PH_SEP : PH_HALT;
            end
            PH_SEP: begin
                n_phase = PH_WIDTH;
            end
            PH_WIDTH: begin
                if (i_byte == SPACE_BYTE) begin
                    n_phase = PH_HEIGHT;
                end else begin
                    n_width = f_add_digit(cur_width, i_byte);
                end
            end
            PH_HEIGHT: begin
                if (i_byte == NEWLINE_BYTE) begin
                    n_phase = PH_MAXVAL;
                end else begin
                    n_height = f_add_digit(cur_height, i_byte);
                end
            end
            PH_MAXVAL: begin
                if (i_byte == NEWLINE_BYTE) begin
                    n_phase = PH_PIXELS;
                    n_bip   = BIP_RED;
                end
            end
            PH_PIXELS: begin
                if (cur_bip == BIP_RED) begin
                    n_red = i_byte;
                    n_bip = BIP_GREEN;
                end else if (cur_bip == BIP_GREEN) begin
                    n_green = i_byte;
                    n_bip   = BIP_BLUE;
                end else begin
                    n_bip = BIP_RED;
                    if (col_inc >= cur_width) begin
                        n_col = '0;
                        n_row = cur_row + 1'b1;
                    end else begin
                        n_col = col_inc;
                    end
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    assign width_ext  = 32'(cur_width);
    assign height_ext = 32'(cur_height);

    always_comb begin
        produce      = 1'b0;
        o_req.kind   = KIND_PIXEL;
        o_req.color  = '0;
        o_req.width  = '0;
        o_req.height = '0;
        unique case (cur_phase)
            PH_MAGIC0: begin
                produce    = (i_byte != MAGIC0_BYTE);
                o_req.kind = KIND_BADMAGIC;
            end
            PH_MAGIC1: begin
                produce    = (i_byte != MAGIC1_BYTE);
                o_req.kind = KIND_BADMAGIC;
            end
            PH_HEIGHT: begin
                produce      = (i_byte == NEWLINE_BYTE);
                o_req.kind   = KIND_HEADER;
                o_req.width  = width_ext[15:0];
                o_req.height = height_ext[15:0];
            end
            PH_PIXELS: begin
                produce     = (cur_bip != BIP_RED) && (cur_bip != BIP_GREEN);
                o_req.kind  = KIND_PIXEL;
                o_req.color = {cur_red, cur_green, i_byte};
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    assign o_req_valid = i_valid && produce;
    assign o_row       = cur_row;
    assign o_col       = cur_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_width  <= '0;
            r_height <= '0;
            r_bip    <= BIP_RED;
            r_red    <= '0;
            r_green  <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_bip    <= n_bip;
            r_red    <= n_red;
            r_green  <= n_green;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

// ----- src/ppf_queue.sv -----
module ppf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import ppf_pkg::*;

    logic [WIDTH-1:0]          r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_ready = (r_count != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/ppf_back.sv -----
module ppf_back #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ppf_pkg::t_req       i_q_req,
    input  logic [DIM_BITS-1:0] i_q_row,
    input  logic [DIM_BITS-1:0] i_q_col,
    output logic                o_pop,
    input  logic [31:0]         i_frame_base,
    input  logic [15:0]         i_line_stride,
    output logic                o_valid,
    input  logic                i_ready,
    output ppf_pkg::t_req       o_req,
    output logic [31:0]         o_addr
);
    import ppf_pkg::*;

    logic                r_s1_valid;
    t_req                r_s1_req;
    logic [DIM_BITS-1:0] r_s1_col;
    logic [31:0]         r_s1_prod;
    logic                r_out_valid;
    t_req                r_out_req;
    logic [31:0]         r_out_addr;
    logic                s1_ready;
    logic                s2_ready;
    logic [31:0]         n_prod;
    logic [31:0]         n_addr;

    assign s2_ready = !r_out_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_pop    = i_q_valid && s1_ready;
    assign n_prod   = 32'(i_line_stride) * 32'(i_q_row);

    always_comb begin
        if (r_s1_req.kind == KIND_PIXEL) begin
            n_addr = i_frame_base + (r_s1_prod << 2) + (32'(r_s1_col) << 2);
        end else begin
            n_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_req  <= i_q_req;
            r_s1_col  <= i_q_col;
            r_s1_prod <= n_prod;
        end
        if (r_s1_valid && s2_ready) begin
            r_out_req  <= r_s1_req;
            r_out_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_q_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_req   = r_out_req;
    assign o_addr  = r_out_addr;

endmodule

// ----- src/ppm_p6_framebuffer_writer.sv -----
// Binary PPM (P6) image to framebuffer pixel writes.
// Slave stream: one file byte per request on tdata, tuser high on the first
// byte of a file restarts header parsing. Master stream: one result per
// request that makes one, kind on tuser (pixel write, header parsed, bad
// magic), address, color and parsed size on tdata.
// Configuration channel: index 0 writes the frame base byte address,
// index 1 the line stride in pixels; always ready.
// Throughput: one byte per cycle while the queue has room. The parser
// updates its state in the cycle a byte is taken; a four-entry queue then
// feeds a two-stage address unit (stride by row multiply, then base and
// column add). A result is held in the queue, the multiply stage and the
// output register in turn before it appears on the master side.
// Receiver stall: results back up into the output register, address stage
// and queue; the slave side drops tready only when the queue is full.
// Reset: synchronous, active low; clears the parser to expect the first
// magic byte, empties the queue and pipeline, zeros base and stride.
module ppm_p6_framebuffer_writer #(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] file_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] start_of_file
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // [31:0] write_address, [55:32] pixel_color,
                                          // [71:56] image_width, [87:72] image_height
    output logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ppf_pkg::*;

    localparam int Q_WIDTH = $bits(t_req) + 2 * DIM_BITS;

    logic [31:0]         r_frame_base;
    logic [15:0]         r_line_stride;
    logic                front_req_valid;
    t_req                front_req;
    logic [DIM_BITS-1:0] front_row;
    logic [DIM_BITS-1:0] front_col;
    logic                q_ready;
    logic                q_valid;
    logic [Q_WIDTH-1:0]  q_data;
    t_req                q_req;
    logic [DIM_BITS-1:0] q_row;
    logic [DIM_BITS-1:0] q_col;
    logic                q_pop;
    t_req                out_req;
    logic [31:0]         out_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base  <= '0;
            r_line_stride <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_BASE:  r_frame_base  <= i_cfg_data;
                REG_LINE_STRIDE: r_line_stride <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ppf_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_start     (i_s_axis_tuser[0]),
        .o_req_valid (front_req_valid),
        .o_req       (front_req),
        .o_row       (front_row),
        .o_col       (front_col),
        .i_req_ready (q_ready)
    );

    ppf_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_req_valid),
        .i_data  ({front_req, front_row, front_col}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign {q_req, q_row, q_col} = q_data;

    ppf_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .i_q_row       (q_row),
        .i_q_col       (q_col),
        .o_pop         (q_pop),
        .i_frame_base  (r_frame_base),
        .i_line_stride (r_line_stride),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_req         (out_req),
        .o_addr        (out_addr)
    );

    assign o_m_axis_tdata = {out_req.height, out_req.width, out_req.color, out_addr};
    assign o_m_axis_tuser = out_req.kind;

endmodule
